>>> rtl/blm_pkg.sv
// Shared widths, register codes, reset values and divider request and result types.
`timescale 1ns / 1ps

package blm_pkg;

    localparam int MV_W        = 17;
    localparam int LEVEL_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DEFAULT_TAPS = 5;

    // Divider geometry: 31-bit dividend, 17-bit divisor, 17-bit quotient.
    localparam int DIVD_W = 31;
    localparam int DIVS_W = 17;
    localparam int QUOT_W = 17;

    localparam logic [MV_W-1:0] CUT_START_RST = 17'd34000;
    localparam logic [MV_W-1:0] CUT_END_RST   = 17'd30000;
    localparam logic [MV_W-1:0] LEVEL2_RST    = 17'd36000;
    localparam logic [MV_W-1:0] LEVEL3_RST    = 17'd38000;
    localparam logic [MV_W-1:0] LEVEL4_RST    = 17'd40000;
    localparam logic [MV_W-1:0] FULL_RST      = 17'd57000;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CUT_START = 3'd0,
        REG_CUT_END   = 3'd1,
        REG_LEVEL2    = 3'd2,
        REG_LEVEL3    = 3'd3,
        REG_LEVEL4    = 3'd4,
        REG_FULL      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quotient;
    } div_res_t;

endpackage

>>> rtl/blm_ring.sv
// Sample ring buffer with write pointer, cleared to zero at reset.
`timescale 1ns / 1ps

module blm_ring
    import blm_pkg::*;
#(
    parameter int TAPS  = DEFAULT_TAPS,
    parameter int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [MV_W-1:0]  wr_data,
    input  logic [PTR_W-1:0] rd_idx,
    output logic [MV_W-1:0]  rd_data
);

    logic [MV_W-1:0]  ring_reg [TAPS];
    logic [PTR_W-1:0] ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                ring_reg[i] <= '0;
            end
            ptr_reg <= '0;
        end
        else if (wr_en)
        begin
            ring_reg[ptr_reg] <= wr_data;
            if (ptr_reg == PTR_W'(TAPS - 1))
            begin
                ptr_reg <= '0;
            end
            else
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    // Indexes past the last tap read as zero.
    assign rd_data = (32'(rd_idx) < TAPS) ? ring_reg[rd_idx] : '0;

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ptr_reg) < TAPS)
        else $error("ring pointer left the ring");

endmodule

>>> rtl/blm_divider.sv
// Shared restoring divider, one quotient bit per cycle with overflow detect.
`timescale 1ns / 1ps

module blm_divider
    import blm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    localparam int DSH_W = DIVS_W + QUOT_W;
    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DIVD_W-1:0] rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ovf_reg;
    logic              ge;

    assign ge = {{(DSH_W - DIVD_W){1'b0}}, rem_reg} >= dsh_reg;

    // The first step tests the dividend against divisor * 2^QUOT_W; if it is
    // not below, the quotient does not fit and is flagged as overflow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            quot_reg <= '0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsh_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= req.dividend;
                dsh_reg  <= {req.divisor, {QUOT_W{1'b0}}};
                cnt_reg  <= CNT_W'(QUOT_W);
                quot_reg <= '0;
                ovf_reg  <= 1'b0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(QUOT_W))
                begin
                    if (ge)
                    begin
                        ovf_reg  <= 1'b1;
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        dsh_reg <= dsh_reg >> 1;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                else
                begin
                    if (ge)
                    begin
                        rem_reg <= rem_reg - dsh_reg[DIVD_W-1:0];
                    end
                    quot_reg <= {quot_reg[QUOT_W-2:0], ge};
                    dsh_reg  <= dsh_reg >> 1;
                    if (cnt_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
            end
        end
    end

    assign res.busy     = busy_reg;
    assign res.done     = done_reg;
    assign res.ovf      = ovf_reg;
    assign res.quotient = quot_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

>>> rtl/battery_level_monitor.sv
// Battery level monitor: moving average, low-battery hysteresis, charge map.
`timescale 1ns / 1ps
// Flow: a motor-off request sums the ring, then divides by the tap count on the shared
// divider, picks the segment and divides again for the slope (skipped on a zero span);
// a motor-running request goes straight to the output stage. A new request is taken only
// once the last one has been loaded for output; it is accepted while that result waits.
// Reset: asynchronous, active low; clears the ring, pointer, flag and average,
// sets the level to full and loads the default thresholds. No clearing pass.

module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int FILTER_TAPS = DEFAULT_TAPS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Sample requests.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [16:0] sample_mv
    input  logic [0:0]           s_tuser,   // [0] motor_off
    // Results.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // [0] low_battery, [16:1] charge_level,
                                            // [33:17] average_mv
    // Threshold register writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MV_W-1:0]      cfg_data
);

    localparam int PTR_W = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
    localparam int CNT_W = $clog2(FILTER_TAPS + 1);
    localparam int SUM_W = MV_W + ((FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 0);
    localparam int SPAN_W = MV_W + 1;

    // Motor-off requests walk: sum the ring, divide by the tap count, pick the segment,
    // divide for the slope unless the span is zero, then hand the result to the output.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SUM  = 6'b000010,
        S_AVG  = 6'b000100,
        S_SEG  = 6'b001000,
        S_MAP  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Threshold registers.
    logic [MV_W-1:0] cut_start_reg, cut_end_reg, level2_reg, level3_reg;
    logic [MV_W-1:0] level4_reg, full_reg;

    // Held monitor state.
    logic               low_flag_reg, low_flag_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [MV_W-1:0]    average_reg, average_next;

    // Working registers.
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       seg_reg, seg_next;
    logic             neg_reg, neg_next;

    // Output register.
    logic               m_tvalid_reg, m_tvalid_next;
    logic               out_low_reg, out_low_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    logic [MV_W-1:0]    out_avg_reg, out_avg_next;

    logic            in_accept;
    logic            ring_wr;
    logic [MV_W-1:0] ring_rd;
    div_req_t        div_req;
    div_res_t        div_res;
    logic            out_free;

    // Segment selection, worked from the stored average.
    logic [MV_W-1:0]    seg_lo_mv, seg_hi_mv;
    logic [1:0]         seg_sel;
    logic [SPAN_W-1:0]  num_s, span_s;
    logic [MV_W-1:0]    num_mag, span_mag;
    logic [LEVEL_W-1:0] seg_lo_level;
    logic [LEVEL_W+1:0] pos_sum;
    logic [LEVEL_W-1:0] level_calc;
    logic [MV_W-1:0]    avg_new;
    logic               low_tmp;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign ring_wr   = in_accept && s_tuser[0];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    blm_ring #(
        .TAPS  (FILTER_TAPS),
        .PTR_W (PTR_W)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ring_wr),
        .wr_data (s_tdata[MV_W-1:0]),
        .rd_idx  (cnt_reg[PTR_W-1:0]),
        .rd_data (ring_rd)
    );

    blm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_start_reg <= CUT_START_RST;
            cut_end_reg   <= CUT_END_RST;
            level2_reg    <= LEVEL2_RST;
            level3_reg    <= LEVEL3_RST;
            level4_reg    <= LEVEL4_RST;
            full_reg      <= FULL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CUT_START: cut_start_reg <= cfg_data;
                REG_CUT_END:   cut_end_reg   <= cfg_data;
                REG_LEVEL2:    level2_reg    <= cfg_data;
                REG_LEVEL3:    level3_reg    <= cfg_data;
                REG_LEVEL4:    level4_reg    <= cfg_data;
                REG_FULL:      full_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The lowest segment runs from the cut-start threshold up to level 2.
    always_comb
    begin
        if (average_reg >= level4_reg)
        begin
            seg_lo_mv = level4_reg;
            seg_hi_mv = full_reg;
            seg_sel   = 2'd3;
        end
        else if (average_reg >= level3_reg)
        begin
            seg_lo_mv = level3_reg;
            seg_hi_mv = level4_reg;
            seg_sel   = 2'd2;
        end
        else if (average_reg >= level2_reg)
        begin
            seg_lo_mv = level2_reg;
            seg_hi_mv = level3_reg;
            seg_sel   = 2'd1;
        end
        else
        begin
            seg_lo_mv = cut_start_reg;
            seg_hi_mv = level2_reg;
            seg_sel   = 2'd0;
        end
        num_s    = {1'b0, average_reg} - {1'b0, seg_lo_mv};
        span_s   = {1'b0, seg_hi_mv} - {1'b0, seg_lo_mv};
        num_mag  = num_s[SPAN_W-1] ? MV_W'(-num_s) : num_s[MV_W-1:0];
        span_mag = span_s[SPAN_W-1] ? MV_W'(-span_s) : span_s[MV_W-1:0];
    end

    // Signed slope result: the divider returns the magnitude of the truncated
    // quotient, the sign is applied here and the sum is clamped to 16 bits.
    always_comb
    begin
        seg_lo_level = {seg_reg, 14'd0};
        pos_sum      = {2'b00, seg_lo_level} + {1'b0, div_res.quotient};
        if (neg_reg)
        begin
            if (div_res.ovf || (div_res.quotient > {1'b0, seg_lo_level}))
            begin
                level_calc = '0;
            end
            else
            begin
                level_calc = seg_lo_level - div_res.quotient[LEVEL_W-1:0];
            end
        end
        else if (div_res.ovf || (pos_sum > {2'b00, LEVEL_FULL}))
        begin
            level_calc = LEVEL_FULL;
        end
        else
        begin
            level_calc = pos_sum[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        low_flag_next  = low_flag_reg;
        level_next     = level_reg;
        average_next   = average_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        seg_next       = seg_reg;
        neg_next       = neg_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_low_next   = out_low_reg;
        out_level_next = out_level_reg;
        out_avg_next   = out_avg_reg;
        div_req        = '0;
        avg_new        = div_res.quotient;
        low_tmp        = low_flag_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    // A request taken while the motor runs only reports held values.
                    state_next = s_tuser[0] ? S_SUM : S_FIN;
                end
            end
            S_SUM:
            begin
                if (cnt_reg == CNT_W'(FILTER_TAPS))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIVD_W'(acc_reg);
                    div_req.divisor  = DIVS_W'(FILTER_TAPS);
                    state_next       = S_AVG;
                end
                else
                begin
                    acc_next = acc_reg + SUM_W'(ring_rd);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_AVG:
            begin
                if (div_res.done)
                begin
                    average_next = avg_new;
                    // Clearing is tested first, then setting, on the new average.
                    if (low_tmp && (avg_new > cut_start_reg))
                    begin
                        low_tmp = 1'b0;
                    end
                    if (!low_tmp && (avg_new < cut_end_reg))
                    begin
                        low_tmp = 1'b1;
                    end
                    low_flag_next = low_tmp;
                    state_next    = S_SEG;
                end
            end
            S_SEG:
            begin
                seg_next = seg_sel;
                neg_next = num_s[SPAN_W-1] ^ span_s[SPAN_W-1];
                if (span_s == '0)
                begin
                    // A zero-width segment reports its low level.
                    level_next = {seg_sel, 14'd0};
                    state_next = S_FIN;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {num_mag, 14'd0};
                    div_req.divisor  = span_mag;
                    state_next       = S_MAP;
                end
            end
            S_MAP:
            begin
                if (div_res.done)
                begin
                    level_next = level_calc;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    out_low_next   = low_flag_reg;
                    out_level_next = level_reg;
                    out_avg_next   = average_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            low_flag_reg <= 1'b0;
            level_reg    <= LEVEL_FULL;
            average_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            seg_reg      <= '0;
            neg_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            low_flag_reg <= low_flag_next;
            level_reg    <= level_next;
            average_reg  <= average_next;
            m_tvalid_reg <= m_tvalid_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            seg_reg      <= seg_next;
            neg_reg      <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_low_reg   <= out_low_next;
        out_level_reg <= out_level_next;
        out_avg_reg   <= out_avg_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_avg_reg, out_level_reg, out_low_reg};

    a_run_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !s_tuser[0]) |=> (state_reg == S_FIN))
        else $error("motor-running request did not go straight to the output");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("finished result was not loaded into the output register");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_AVG || state_reg == S_MAP) && !div_res.done) |-> div_res.busy)
        else $error("sequencer waits on an idle divider");

endmodule

>>> tb/sv/blm_reading_checker.sv
// Checker that predicts each battery monitor reading and compares it with the block's result.
`timescale 1ns / 1ps

module blm_reading_checker
    import blm_pkg::*;
#(
    parameter int TAPS = DEFAULT_TAPS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [16:0] sample_mv
    input  logic [0:0]           s_tuser,   // [0] motor_off
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [39:0]          m_tdata,   // [0] low_battery, [16:1] charge_level,
                                            // [33:17] average_mv
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MV_W-1:0]      cfg_data,
    output int                   mismatches,
    output int                   readings_due
);

    typedef struct packed {
        logic               low_battery;
        logic [LEVEL_W-1:0] charge_level;
        logic [MV_W-1:0]    average_mv;
    } reading_t;

    localparam longint SEG_STEP      = 16384;
    localparam longint QUARTER       = 16384;
    localparam longint HALF          = 32768;
    localparam longint THREE_QUARTER = 49152;
    localparam longint LEVEL_CEILING = 65535;

    logic [MV_W-1:0]    cut_start_mv;
    logic [MV_W-1:0]    cut_end_mv;
    logic [MV_W-1:0]    level2_mv;
    logic [MV_W-1:0]    level3_mv;
    logic [MV_W-1:0]    level4_mv;
    logic [MV_W-1:0]    full_mv;

    logic [MV_W-1:0]    ring [TAPS];
    int                 ring_ptr;
    logic               low_flag;
    logic [LEVEL_W-1:0] level_held;
    logic [MV_W-1:0]    average_held;
    reading_t           pending_readings [$];
    int                 reading_no;

    // Linear interpolation inside one segment, truncated toward zero, then clamped.
    function automatic logic [LEVEL_W-1:0] segment_level(input logic [MV_W-1:0] avg,
                                                         input logic [MV_W-1:0] lo_mv,
                                                         input logic [MV_W-1:0] hi_mv,
                                                         input longint base);
        longint a;
        longint lo;
        longint hi;
        longint span;
        longint lvl;
        a    = avg;
        lo   = lo_mv;
        hi   = hi_mv;
        span = hi - lo;
        lvl  = base;
        if (span != 0)
            lvl = lvl + ((a - lo) * SEG_STEP) / span;
        if (lvl < 0)
            lvl = 0;
        if (lvl > LEVEL_CEILING)
            lvl = LEVEL_CEILING;
        return lvl[LEVEL_W-1:0];
    endfunction

    task automatic absorb_sample(input logic [MV_W-1:0] sample, input logic motor_off);
        int unsigned     sum;
        logic [MV_W-1:0] avg;
        reading_t        r;
        int              i;
        if (motor_off)
        begin
            ring[ring_ptr] = sample;
            ring_ptr = (ring_ptr + 1 >= TAPS) ? 0 : ring_ptr + 1;
            sum = 0;
            for (i = 0; i < TAPS; i++)
                sum += ring[i];
            avg = MV_W'(sum / TAPS);
            average_held = avg;

            if (low_flag && avg > cut_start_mv)
                low_flag = 1'b0;
            if (!low_flag && avg < cut_end_mv)
                low_flag = 1'b1;

            if (avg >= level4_mv)
                level_held = segment_level(avg, level4_mv, full_mv, THREE_QUARTER);
            else if (avg >= level3_mv)
                level_held = segment_level(avg, level3_mv, level4_mv, HALF);
            else if (avg >= level2_mv)
                level_held = segment_level(avg, level2_mv, level3_mv, QUARTER);
            else
                level_held = segment_level(avg, cut_start_mv, level2_mv, 0);
        end
        r.low_battery  = low_flag;
        r.charge_level = level_held;
        r.average_mv   = average_held;
        pending_readings.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch on reading %0d: %s", $time, reading_no, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t seen;
        reading_t want;
        int       i;
        if (!rst_n)
        begin
            cut_start_mv = CUT_START_RST;
            cut_end_mv   = CUT_END_RST;
            level2_mv    = LEVEL2_RST;
            level3_mv    = LEVEL3_RST;
            level4_mv    = LEVEL4_RST;
            full_mv      = FULL_RST;
            for (i = 0; i < TAPS; i++)
                ring[i] = '0;
            ring_ptr     = 0;
            low_flag     = 1'b0;
            level_held   = LEVEL_FULL;
            average_held = '0;
            pending_readings.delete();
            reading_no   = 0;
            mismatches   = 0;
            readings_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CUT_START: cut_start_mv = cfg_data;
                    REG_CUT_END:   cut_end_mv   = cfg_data;
                    REG_LEVEL2:    level2_mv    = cfg_data;
                    REG_LEVEL3:    level3_mv    = cfg_data;
                    REG_LEVEL4:    level4_mv    = cfg_data;
                    REG_FULL:      full_mv      = cfg_data;
                    default:       ;
                endcase
            end

            // A result leaving at this edge belongs to an earlier request.
            if (m_tvalid && m_tready)
            begin
                seen.low_battery  = m_tdata[0];
                seen.charge_level = m_tdata[16:1];
                seen.average_mv   = m_tdata[33:17];
                if (pending_readings.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    want = pending_readings.pop_front();
                    if (seen.low_battery !== want.low_battery)
                        report_mismatch($sformatf("low_battery %b, want %b",
                                                  seen.low_battery, want.low_battery));
                    if (seen.charge_level !== want.charge_level)
                        report_mismatch($sformatf("charge_level %0d, want %0d",
                                                  seen.charge_level, want.charge_level));
                    if (seen.average_mv !== want.average_mv)
                        report_mismatch($sformatf("average_mv %0d, want %0d",
                                                  seen.average_mv, want.average_mv));
                end
                reading_no++;
            end

            if (s_tvalid && s_tready)
                absorb_sample(s_tdata[MV_W-1:0], s_tuser[0]);

            readings_due <= pending_readings.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top: drives samples, result backpressure and threshold writes, and gives the verdict.
`timescale 1ns / 1ps

module tb_top
    import blm_pkg::*;
();

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int IDLE_PERCENT    = 19;
    localparam int MOTOR_OFF_PCT   = 78;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam logic [MV_W-1:0] MV_MAX = '1;

    // Indexes beyond the register list; the block is expected to ignore writes there.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {
        CFG_ORDERED,
        CFG_ANY,
        CFG_FLAT,
        CFG_INVERTED,
        CFG_ZERO,
        CFG_MAX
    } cfg_style_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;   // [16:0] sample_mv
    logic [0:0]           s_tuser   = '0;   // [0] motor_off
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;          // [0] low_battery, [16:1] charge_level,
                                            // [33:17] average_mv
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MV_W-1:0]      cfg_data  = '0;

    int                   mismatches;
    int                   readings_due;

    // When set, neither side idles. Written with nonblocking assignments by the stimulus.
    logic                 steady        = 1'b0;
    // Each increment asks the result side for one long hold-off.
    int                   hold_requests = 0;

    // Thresholds as last programmed, used to steer random samples toward them.
    logic [MV_W-1:0]      threshold_mv [6];
    logic [MV_W-1:0]      drift_mv;

    cfg_style_t phase_plan [RANDOM_PHASES] = '{CFG_ORDERED, CFG_ANY, CFG_ORDERED, CFG_FLAT,
                                               CFG_ORDERED, CFG_INVERTED, CFG_ZERO, CFG_MAX};

    always #2 clk = ~clk;

    battery_level_monitor #(
        .FILTER_TAPS(DEFAULT_TAPS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    blm_reading_checker #(
        .TAPS(DEFAULT_TAPS)
    ) reading_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .readings_due (readings_due)
    );

    // One register write. The valid is dropped for a cycle afterwards, so that
    // lowering it and raising it for the next write never share a time step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [MV_W-1:0] cut_start, input logic [MV_W-1:0] cut_end,
                                  input logic [MV_W-1:0] lvl2, input logic [MV_W-1:0] lvl3,
                                  input logic [MV_W-1:0] lvl4, input logic [MV_W-1:0] full);
        threshold_mv[REG_CUT_START] = cut_start;
        threshold_mv[REG_CUT_END]   = cut_end;
        threshold_mv[REG_LEVEL2]    = lvl2;
        threshold_mv[REG_LEVEL3]    = lvl3;
        threshold_mv[REG_LEVEL4]    = lvl4;
        threshold_mv[REG_FULL]      = full;
        write_reg(REG_CUT_START, cut_start);
        write_reg(REG_CUT_END, cut_end);
        write_reg(REG_LEVEL2, lvl2);
        write_reg(REG_LEVEL3, lvl3);
        write_reg(REG_LEVEL4, lvl4);
        write_reg(REG_FULL, full);
    endtask

    // Offers one sample request and returns at the edge where it is accepted.
    // The valid stays high into the next request unless an idle gap is drawn.
    task automatic offer_sample(input logic [MV_W-1:0] sample, input logic motor_off);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 24'(sample);
        s_tuser  <= motor_off;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops offering and waits until every predicted reading has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_due != 0)
            @(posedge clk);
    endtask

    task automatic choose_thresholds(input cfg_style_t style);
        int          base;
        int          cs;
        int          ce;
        int          l2;
        int          l3;
        int          l4;
        int          fl;
        logic [31:0] rnd [6];
        int          i;
        for (i = 0; i < 6; i++)
            rnd[i] = $urandom();
        case (style)
            CFG_ORDERED:
            begin
                base = $urandom_range(60000, 20000);
                ce   = base - $urandom_range(5000);
                cs   = base;
                l2   = cs + $urandom_range(4000);
                l3   = l2 + $urandom_range(4000);
                l4   = l3 + $urandom_range(4000);
                fl   = l4 + $urandom_range(30000);
                set_thresholds(MV_W'(cs), MV_W'(ce), MV_W'(l2), MV_W'(l3), MV_W'(l4), MV_W'(fl));
            end
            CFG_ANY:
                set_thresholds(rnd[0][MV_W-1:0], rnd[1][MV_W-1:0], rnd[2][MV_W-1:0],
                               rnd[3][MV_W-1:0], rnd[4][MV_W-1:0], rnd[5][MV_W-1:0]);
            CFG_FLAT:
            begin
                // Every segment has zero span.
                base = $urandom_range(100000);
                set_thresholds(MV_W'(base), MV_W'(base), MV_W'(base), MV_W'(base),
                               MV_W'(base), MV_W'(base));
            end
            CFG_INVERTED:
            begin
                // Segments run downward, so each span is negative.
                fl   = $urandom_range(40000, 10000);
                l4   = fl + $urandom_range(8000, 1);
                l3   = l4 + $urandom_range(8000, 1);
                l2   = l3 + $urandom_range(8000, 1);
                cs   = l2 + $urandom_range(8000, 1);
                ce   = $urandom_range(90000, 10000);
                set_thresholds(MV_W'(cs), MV_W'(ce), MV_W'(l2), MV_W'(l3), MV_W'(l4), MV_W'(fl));
            end
            CFG_ZERO:
                set_thresholds('0, '0, '0, '0, '0, '0);
            default:
                set_thresholds(MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX);
        endcase
    endtask

    // Random samples mostly follow a slowly wandering level that now and then jumps
    // to one of the thresholds, so the average crosses segment edges and the
    // hysteresis band; the rest are extremes and noise over the full 17 bits.
    task automatic next_sample(output logic [MV_W-1:0] sample);
        int          pick;
        int          v;
        logic [31:0] rnd;
        rnd = $urandom();
        if ($urandom_range(99) < 10)
            drift_mv = threshold_mv[$urandom_range(5)];
        pick = $urandom_range(99);
        if (pick < 4)
            sample = '0;
        else if (pick < 8)
            sample = MV_MAX;
        else if (pick < 22)
            sample = rnd[MV_W-1:0];
        else
        begin
            v = int'(drift_mv) + int'($urandom_range(1200)) - 600;
            if (v < 0)
                v = 0;
            if (v > int'(MV_MAX))
                v = int'(MV_MAX);
            sample = MV_W'(v);
            drift_mv = sample;
        end
    endtask

    // Result side: random backpressure, plus a long hold-off on request from the
    // stimulus, counted here in cycles while the sender keeps offering.
    initial
    begin : result_sink
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [MV_W-1:0] sample;
        int              p;
        int              n;
        threshold_mv[REG_CUT_START] = CUT_START_RST;
        threshold_mv[REG_CUT_END]   = CUT_END_RST;
        threshold_mv[REG_LEVEL2]    = LEVEL2_RST;
        threshold_mv[REG_LEVEL3]    = LEVEL3_RST;
        threshold_mv[REG_LEVEL4]    = LEVEL4_RST;
        threshold_mv[REG_FULL]      = FULL_RST;
        drift_mv = CUT_START_RST;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds. A running motor first reports the reset values, then a
        // zero sample drives the average to zero and sets the low flag, and the
        // largest sample repeated past the ring size wraps the pointer, clears the
        // flag and pushes the level into the clamp.
        offer_sample(MV_MAX, 1'b0);
        offer_sample('0, 1'b1);
        repeat (6) offer_sample(MV_MAX, 1'b1);
        offer_sample('0, 1'b0);
        settle();

        // All boundaries equal: every segment has zero span.
        set_thresholds(17'd50000, 17'd50000, 17'd50000, 17'd50000, 17'd50000, 17'd50000);
        repeat (5) offer_sample(17'd50000, 1'b1);
        settle();

        // Boundaries in falling order, with the cut-end above the cut-start.
        set_thresholds(17'd60000, 17'd70000, 17'd50000, 17'd45000, 17'd40000, 17'd20000);
        repeat (3) offer_sample(17'd45000, 1'b1);
        offer_sample(MV_MAX, 1'b1);
        offer_sample('0, 1'b1);
        settle();

        // Both register extremes, and writes to indexes that hold no register.
        set_thresholds('0, '0, '0, '0, '0, '0);
        write_reg(REG_SPARE_LO, MV_MAX);
        write_reg(REG_SPARE_HI, 17'h0AAAA);
        offer_sample(17'd100000, 1'b1);
        offer_sample('0, 1'b1);
        offer_sample(MV_MAX, 1'b0);
        settle();
        set_thresholds(MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX, MV_MAX);
        offer_sample(MV_MAX, 1'b1);
        offer_sample(17'h10000, 1'b1);
        settle();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            choose_thresholds(phase_plan[p]);
            steady <= (p == 4);
            // Hold the result side long enough for the block to fill and stall.
            if (p == 2 || p == 5)
                hold_requests <= hold_requests + 1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                next_sample(sample);
                offer_sample(sample, ($urandom_range(99) < MOTOR_OFF_PCT));
            end
            settle();
        end

        steady <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
